### src/hcbd_pkg.sv
// Package: phase codes, result type and byte constants for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_LF    = 3'd1,
        PH_DATA  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_FINAL = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERR   = 3'd6
    } phase_t;

    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_0          = 8'h30;
    localparam logic [7:0] CHAR_9          = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [7:0] CASE_BIT        = 8'h20;
    localparam logic [3:0] HEX_ALPHA_BASE  = 4'd10;
    localparam logic [1:0] TRAILER_BYTES   = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       message_done;
        logic       framing_error;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit, either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        logic [7:0] lc;
        logic [7:0] off;
        lc = b | CASE_BIT;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (b >= CHAR_0 && b <= CHAR_9) begin
            off     = b - CHAR_0;
            d.valid = 1'b1;
            d.value = off[3:0];
        end
        else if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_F) begin
            off     = lc - CHAR_LOWER_A;
            d.valid = 1'b1;
            d.value = off[3:0] + HEX_ALPHA_BASE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### src/http_chunked_body_decoder.sv
// Top level: HTTP chunked transfer body decoder, one byte per item.
//
// Input channel: in_valid / in_stall with data_byte, one raw body byte per item.
// Output channel: out_valid / out_stall with out_byte, is_payload, message_done
// and framing_error; every input item yields exactly one result item.
// The size line (hex digits, CR LF) is accumulated into a SIZE_BITS counter, then
// that many bytes leave marked as payload, then two trailer bytes are skipped.
// A zero size ends the message; framing_error is sticky once a bad size line or
// a size overflow is seen.
// A result enters the output register if that is free, else the skid register.
// Throughput: one item per cycle while in_stall is low; the decode of a byte is
// a single step of the phase register and byte counter.
// A stalled output holds its result; one further item lands in a skid register
// and in_stall rises only while that skid register is full.
// Reset clears the phase to size reading, the counters to zero and both
// output stages to empty.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            is_payload,
    output logic            message_done,
    output logic            framing_error
);
    import hcbd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   byte_count_reg, byte_count_next;
    logic [1:0]             trailer_left_reg, trailer_left_next;

    result_t                out_reg, out_next;
    result_t                skid_reg, skid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;

    result_t                res;
    hex_digit_t             digit;
    logic                   in_fire;
    logic                   out_fire;
    logic                   out_free;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_fire;

    // Decode step for the byte at the input.
    always_comb
    begin
        digit             = hex_decode(data_byte);
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        trailer_left_next = trailer_left_reg;
        res.out_byte      = data_byte;
        res.is_payload    = 1'b0;

        unique case (phase_reg)
            PH_SIZE:
            begin
                if (digit.valid) begin
                    if (byte_count_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                        phase_next = PH_ERR;
                    end
                    else begin
                        byte_count_next = {byte_count_reg[SIZE_BITS-5:0], digit.value};
                    end
                end
                else if (data_byte == CHAR_CR) begin
                    phase_next = PH_LF;
                end
                else begin
                    phase_next = PH_ERR;
                end
            end
            PH_LF:
            begin
                if (data_byte != CHAR_LF) begin
                    phase_next = PH_ERR;
                end
                else if (byte_count_reg == '0) begin
                    trailer_left_next = TRAILER_BYTES;
                    phase_next        = PH_FINAL;
                end
                else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res.is_payload  = 1'b1;
                byte_count_next = byte_count_reg - 1'b1;
                if (byte_count_next == '0) begin
                    trailer_left_next = TRAILER_BYTES;
                    phase_next        = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                trailer_left_next = trailer_left_reg - 2'd1;
                if (trailer_left_next == 2'd0) begin
                    byte_count_next = '0;
                    phase_next      = PH_SIZE;
                end
            end
            PH_FINAL:
            begin
                trailer_left_next = trailer_left_reg - 2'd1;
                if (trailer_left_next == 2'd0) begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase

        res.message_done  = (phase_next == PH_DONE);
        res.framing_error = (phase_next == PH_ERR);
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            // advance: skid first, else the new item
            out_valid_next  = skid_valid_reg || in_fire;
            out_next        = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (in_fire) begin
            // hold the output, park the new item
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_SIZE;
            byte_count_reg   <= '0;
            trailer_left_reg <= 2'd0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else begin
            if (in_fire) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                trailer_left_reg <= trailer_left_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_reg.out_byte;
    assign is_payload    = out_reg.is_payload;
    assign message_done  = out_reg.message_done;
    assign framing_error = out_reg.framing_error;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output stage empty");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((is_payload && message_done) || (is_payload && framing_error)
                        || (message_done && framing_error)))
        else $error("result flags not mutually exclusive");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && framing_error) |=> (!out_valid || framing_error))
        else $error("framing error cleared after being reported");

    a_err_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |=> (phase_reg == PH_ERR))
        else $error("decoder left the error phase");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for the chunked body decoder: byte-stream stimulus, in-bench decoder, scoreboard.
`timescale 1ns / 1ps

module testbench;

    import hcbd_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int BODY_ITEMS   = 1870;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 5;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum int {
        END_ZERO,
        END_EMPTY,
        END_BARE_LF,
        END_CR_NO_LF,
        END_NON_HEX,
        END_OVERFLOW
    } ending_t;

    // Decodes the body byte by byte and keeps the results still owed by the block.
    class chunk_scoreboard;
        phase_t                 dec_phase;
        logic [SIZE_BITS-1:0]   byte_count;
        logic [1:0]             trailer_left;
        result_t                expected_q[$];
        int                     errors;
        int                     checked;
        int                     payload_checked;

        function new();
            dec_phase       = PH_SIZE;
            byte_count      = '0;
            trailer_left    = '0;
            errors          = 0;
            checked         = 0;
            payload_checked = 0;
        endfunction

        function bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
            logic [7:0] folded;
            folded = b | CASE_BIT;
            v = 4'd0;
            if (b >= CHAR_0 && b <= CHAR_9)
            begin
                v = 4'(b - CHAR_0);
                return 1'b1;
            end
            if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_F)
            begin
                v = 4'(folded - CHAR_LOWER_A) + HEX_ALPHA_BASE;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(input logic [7:0] b);
            logic [3:0] nib;
            result_t    res;
            res = '0;
            case (dec_phase)
                PH_SIZE:
                begin
                    if (hex_nibble(b, nib))
                    begin
                        // a digit with the top nibble already set cannot fit
                        if (byte_count[SIZE_BITS-1 -: 4] != 4'd0)
                            dec_phase = PH_ERR;
                        else
                            byte_count = {byte_count[SIZE_BITS-5:0], nib};
                    end
                    else if (b == CHAR_CR)
                        dec_phase = PH_LF;
                    else
                        dec_phase = PH_ERR;
                end
                PH_LF:
                begin
                    if (b != CHAR_LF)
                        dec_phase = PH_ERR;
                    else if (byte_count == '0)
                    begin
                        trailer_left = TRAILER_BYTES;
                        dec_phase    = PH_FINAL;
                    end
                    else
                        dec_phase = PH_DATA;
                end
                PH_DATA:
                begin
                    res.is_payload = 1'b1;
                    byte_count     = byte_count - 1'b1;
                    if (byte_count == '0)
                    begin
                        trailer_left = TRAILER_BYTES;
                        dec_phase    = PH_TRAIL;
                    end
                end
                PH_TRAIL:
                begin
                    trailer_left = trailer_left - 1'b1;
                    if (trailer_left == 2'd0)
                    begin
                        byte_count = '0;
                        dec_phase  = PH_SIZE;
                    end
                end
                PH_FINAL:
                begin
                    trailer_left = trailer_left - 1'b1;
                    if (trailer_left == 2'd0)
                        dec_phase = PH_DONE;
                end
                PH_DONE:
                begin
                end
                default:
                    dec_phase = PH_ERR;
            endcase
            res.out_byte      = b;
            res.message_done  = (dec_phase == PH_DONE);
            res.framing_error = (dec_phase == PH_ERR);
            expected_q.push_back(res);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result %h arrived with no item outstanding", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte expected %h got %h", $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.is_payload !== want.is_payload)
            begin
                $display("%0t: is_payload expected %b got %b", $time,
                         want.is_payload, got.is_payload);
                errors++;
            end
            if (got.message_done !== want.message_done)
            begin
                $display("%0t: message_done expected %b got %b", $time,
                         want.message_done, got.message_done);
                errors++;
            end
            if (got.framing_error !== want.framing_error)
            begin
                $display("%0t: framing_error expected %b got %b", $time,
                         want.framing_error, got.framing_error);
                errors++;
            end
            checked++;
            if (want.is_payload)
                payload_checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       is_payload;
    logic       message_done;
    logic       framing_error;

    chunk_scoreboard sb;
    int              items_sent;
    int              burst_left;
    bit              gaps_on;
    int              chunks;
    int              cycle_count;
    ending_t         ending;

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_payload   (is_payload),
        .message_done (message_done),
        .framing_error(framing_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Values read here are the ones present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({out_byte, is_payload, message_done, framing_error});
        if (rst_n && in_valid && !in_stall)
            sb.note_input(data_byte);
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < HEX_ALPHA_BASE)
            c = CHAR_0 + 8'(nib);
        else
        begin
            c = CHAR_LOWER_A + 8'(nib - HEX_ALPHA_BASE);
            if ($urandom_range(0, 1) == 1)
                c = c & ~CASE_BIT;
        end
        return c;
    endfunction

    // Any byte that is neither a hex digit nor CR nor LF.
    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        logic [3:0] nib;
        case ($urandom_range(0, 3))
            0: return CHAR_SEMI;
            1: return CHAR_SPACE;
            default:
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (sb.hex_nibble(b, nib) || b == CHAR_CR || b == CHAR_LF);
                return b;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
    endtask

    // Drop valid and hold until every result is back.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_byte(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic send_head(input logic [31:0] chunk_size, input int pad);
        int ndig;
        int i;
        ndig = 1;
        for (i = 1; i < 8; i++)
            if ((chunk_size >> (4 * i)) != 0)
                ndig = i + 1;
        ndig = (ndig + pad > 8) ? 8 : ndig + pad;
        for (i = ndig - 1; i >= 0; i--)
            send_byte(hex_char(chunk_size[4 * i +: 4]));
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_trailer();
        if ($urandom_range(0, 3) != 0)
        begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_chunk(input int chunk_size, input int pad);
        send_head(chunk_size, pad);
        repeat (chunk_size) send_byte(8'($urandom_range(0, 255)));
        send_trailer();
        chunks++;
    endtask

    task automatic send_ending();
        case (ending)
            END_ZERO:
            begin
                send_head(0, $urandom_range(0, 3));
                send_trailer();
            end
            END_EMPTY:
            begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                send_trailer();
            end
            END_BARE_LF:
            begin
                send_digits($urandom_range(0, 3));
                send_byte(CHAR_LF);
            end
            END_CR_NO_LF:
            begin
                send_digits($urandom_range(0, 3));
                send_byte(CHAR_CR);
                send_byte(($urandom_range(0, 1) == 0) ? CHAR_CR : stray_byte());
            end
            END_NON_HEX:
            begin
                send_digits($urandom_range(0, 3));
                send_byte(stray_byte());
            end
            default:
            begin
                // eight digits with a nonzero lead fill the counter; the ninth overflows
                send_byte(hex_char(4'($urandom_range(1, 15))));
                send_digits(8);
            end
        endcase
    endtask

    // Receiver: hold off long once while the opening items pile up, then mix patterns.
    initial
    begin
        int mode;
        int len;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (30) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(10, 120);
            if (mode == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                repeat (len)
                begin
                    if (mode <= 3)
                        out_stall <= 1'b0;
                    else if (mode <= 6)
                        out_stall <= ($urandom_range(0, 3) == 0);
                    else
                        out_stall <= ($urandom_range(0, 1) == 1);
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cycle limit hit with %0d results outstanding", sb.pending());
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        int r;
        int chunk_size;
        sb         = new();
        items_sent = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        chunks     = 0;
        ending     = ending_t'($urandom_range(0, 5));
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening items back to back: smallest chunk, byte extremes, eight-digit size line.
        send_head(1, 0);
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_head(2, 7);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h00);
        chunks += 2;
        pause_until_drained();

        gaps_on = 1'b1;
        while (items_sent < BODY_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                chunk_size = $urandom_range(1, 16);
            else if (r < 95)
                chunk_size = $urandom_range(17, 200);
            else
                chunk_size = $urandom_range(201, 600);
            send_chunk(chunk_size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0);
            if ($urandom_range(0, 24) == 0)
                pause_until_drained();
        end

        send_ending();
        // Bytes after the end of the message or an error leave the phase as it is; each still yields a result.
        repeat (24) send_byte(8'($urandom_range(0, 255)));
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items in %0d chunks, %0d payload bytes checked",
                 sb.checked, chunks, sb.payload_checked);
        $display("message closed by %s, %0d mismatches", ending.name(), sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
